>>> src/packed_code_dot_product_unit_assert.svh
// Assertion macros shared by the dot product unit.
`ifndef PACKED_CODE_DOT_PRODUCT_UNIT_ASSERT_SVH
`define PACKED_CODE_DOT_PRODUCT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define PCDP_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pcdp assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define PCDP_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("pcdp assertion failed");

`else

`define PCDP_ASSERT(label, clk, rst, cond)
`define PCDP_ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

>>> src/pcdp_pkg.sv
`default_nettype none

package pcdp_pkg;

  // Longest vector the saturation limit is sized for.
  localparam int unsigned MAX_ELEMENTS = 32768;

  // Saturation limit of the running sum: MAX_ELEMENTS * 255 * 255.
  localparam logic [31:0] SUM_LIMIT = 32'(64'(MAX_ELEMENTS) * 64'd65025);

  localparam logic [7:0] CODE_MASK6 = 8'h3F;
  localparam logic [7:0] CODE_MASK7 = 8'h7F;

  localparam logic [3:0] DEPTH_MIN   = 4'd6;
  localparam logic [3:0] DEPTH_MAX   = 4'd8;
  localparam logic [3:0] DEPTH_RESET = 4'd8;

  // Up to two matching code pairs unpacked from one byte pair.
  typedef struct packed {
    logic [7:0] code_a0;
    logic [7:0] code_b0;
    logic [7:0] code_a1;
    logic [7:0] code_b1;
    logic       second;
    logic       last;
  } code_pair_t;

  // Clamp the depth register to the supported range.
  function automatic logic [3:0] effective_depth(input logic [3:0] raw);
    logic [3:0] d;
    d = raw;
    if (raw < DEPTH_MIN) d = DEPTH_MIN;
    if (raw > DEPTH_MAX) d = DEPTH_MAX;
    return d;
  endfunction

  // Code mask for a clamped depth.
  function automatic logic [7:0] depth_mask(input logic [3:0] d);
    logic [7:0] m;
    m = 8'hFF;
    if (d == DEPTH_MIN) m = CODE_MASK6;
    if (d == DEPTH_MIN + 4'd1) m = CODE_MASK7;
    return m;
  endfunction

endpackage

`default_nettype wire

>>> src/packed_code_dot_product_unit.sv
`default_nettype none

// Dot product of two streams of packed unsigned codes (6, 7 or 8 bits, set by
// the code depth register; other values clamp into that range). One byte of
// each stream is taken per request, a new request every cycle while in_stall
// is low; up to two code pairs are cut from each byte pair, multiplied and
// summed with saturation at 2130739200. The request flagged last_byte yields
// one result; leftover bits are dropped and the unit restarts clean. The
// request sits in the input register, then passes the unpack register and the
// product register before the accumulator loads the output register. A final
// request waits in the product register while an earlier result is held
// stalled at the output. The pending bit window and the running sum are the
// only loops, so throughput is one byte pair per cycle while results are
// taken. Write the depth only while no vector is in flight.
module packed_code_dot_product_unit import pcdp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] byte_a,
  input  wire logic [7:0] byte_b,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [30:0]     dot_product
);

  logic [3:0] code_depth;
  logic [3:0] depth;
  logic       pair_valid;
  logic       pair_stall;
  code_pair_t pair;

  // Depth register.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_depth <= DEPTH_RESET;
    end else if (cfg_wr_en) begin
      code_depth <= cfg_wr_data;
    end
  end

  assign depth = effective_depth(code_depth);

  pcdp_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .depth      (depth),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_a     (byte_a),
    .byte_b     (byte_b),
    .last_byte  (last_byte),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair)
  );

  pcdp_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .pair        (pair),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dot_product (dot_product)
  );

endmodule

`default_nettype wire

>>> src/pcdp_unpack.sv
`default_nettype none

`include "packed_code_dot_product_unit_assert.svh"

module pcdp_unpack import pcdp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [3:0] depth,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] byte_a,
  input  wire logic [7:0] byte_b,
  input  wire logic       last_byte,
  output logic            pair_valid,
  input  wire logic       pair_stall,
  output code_pair_t      pair
);

  logic       s0_valid;
  logic [7:0] s0_byte_a;
  logic [7:0] s0_byte_b;
  logic       s0_last;

  // Pending bits stay below eight after every item.
  logic [6:0] pend_a;
  logic [6:0] pend_b;
  logic [2:0] pend_count;

  logic        s0_ready;
  logic        s1_ready;
  logic [14:0] buf_a;
  logic [14:0] buf_b;
  logic [3:0]  total;
  logic [4:0]  twice_depth;
  logic        two_codes;
  logic [7:0]  mask;
  logic [6:0]  pend_a_next;
  logic [6:0]  pend_b_next;
  logic [2:0]  pend_count_next;
  code_pair_t  pair_next;

  // Stage readiness: a stage moves when empty or when its successor moves.
  assign s1_ready = !pair_valid || !pair_stall;
  assign s0_ready = !s0_valid || s1_ready;
  assign in_stall = !s0_ready;

  // Append the new bytes above the pending bits and cut up to two codes.
  always_comb begin
    mask        = depth_mask(depth);
    buf_a       = 15'(pend_a) | (15'(s0_byte_a) << pend_count);
    buf_b       = 15'(pend_b) | (15'(s0_byte_b) << pend_count);
    total       = 4'(pend_count) + 4'd8;
    twice_depth = {depth, 1'b0};
    two_codes   = 5'(total) >= twice_depth;

    pair_next.code_a0 = buf_a[7:0] & mask;
    pair_next.code_b0 = buf_b[7:0] & mask;
    pair_next.code_a1 = 8'(buf_a >> depth) & mask;
    pair_next.code_b1 = 8'(buf_b >> depth) & mask;
    pair_next.second  = two_codes;
    pair_next.last    = s0_last;

    if (two_codes) begin
      pend_a_next     = 7'(buf_a >> twice_depth);
      pend_b_next     = 7'(buf_b >> twice_depth);
      pend_count_next = 3'(5'(total) - twice_depth);
    end else begin
      pend_a_next     = 7'(buf_a >> depth);
      pend_b_next     = 7'(buf_b >> depth);
      pend_count_next = 3'(total - depth);
    end

    // Drop leftover bits at the end of a vector.
    if (s0_last) begin
      pend_a_next     = '0;
      pend_b_next     = '0;
      pend_count_next = '0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= in_valid;
    end
    if (s0_ready && in_valid) begin
      s0_byte_a <= byte_a;
      s0_byte_b <= byte_b;
      s0_last   <= last_byte;
    end
  end

  // Code register and pending bit state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      pend_a     <= '0;
      pend_b     <= '0;
      pend_count <= '0;
    end else if (s1_ready) begin
      pair_valid <= s0_valid;
      if (s0_valid) begin
        pend_a     <= pend_a_next;
        pend_b     <= pend_b_next;
        pend_count <= pend_count_next;
      end
    end
    if (s1_ready && s0_valid) begin
      pair <= pair_next;
    end
  end

  `PCDP_ASSERT(a_pend_a_clean, clk, rst, (15'(pend_a) >> pend_count) == 15'd0)
  `PCDP_ASSERT(a_pend_b_clean, clk, rst, (15'(pend_b) >> pend_count) == 15'd0)
  `PCDP_ASSERT_NEXT(a_last_clears, clk, rst, s1_ready && s0_valid && s0_last,
                    pend_count == 3'd0 && pend_a == 7'd0 && pend_b == 7'd0)

endmodule

`default_nettype wire

>>> src/pcdp_mac.sv
`default_nettype none

`include "packed_code_dot_product_unit_assert.svh"

module pcdp_mac import pcdp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  pair_valid,
  output logic       pair_stall,
  input  code_pair_t pair,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [30:0] dot_product
);

  logic        prod_valid;
  logic [15:0] prod0;
  logic [15:0] prod1;
  logic        prod_last;
  logic [30:0] running_sum;

  logic        acc_ready;
  logic        s2_ready;
  logic        acc_fire;
  logic [31:0] sum_wide;
  logic [30:0] sum_sat;

  // A final request waits only while the output register is full and stalled.
  assign acc_ready  = !(prod_last && out_valid && out_stall);
  assign s2_ready   = !prod_valid || acc_ready;
  assign pair_stall = !s2_ready;
  assign acc_fire   = prod_valid && acc_ready;

  // Add both products and clamp at the limit.
  always_comb begin
    sum_wide = 32'(running_sum) + 32'(prod0) + 32'(prod1);
    sum_sat  = (sum_wide > SUM_LIMIT) ? 31'(SUM_LIMIT) : 31'(sum_wide);
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (s2_ready) begin
      prod_valid <= pair_valid;
    end
    if (s2_ready && pair_valid) begin
      prod0     <= 16'(pair.code_a0) * 16'(pair.code_b0);
      prod1     <= pair.second ? 16'(pair.code_a1) * 16'(pair.code_b1) : 16'd0;
      prod_last <= pair.last;
    end
  end

  // Accumulate; on the final request move the sum out and restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (acc_fire) begin
        running_sum <= prod_last ? 31'd0 : sum_sat;
      end
      if (acc_fire && prod_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (acc_fire && prod_last) begin
      dot_product <= sum_sat;
    end
  end

  `PCDP_ASSERT(a_sum_bounded, clk, rst, 32'(running_sum) <= SUM_LIMIT)
  `PCDP_ASSERT(a_out_bounded, clk, rst, !out_valid || 32'(dot_product) <= SUM_LIMIT)
  `PCDP_ASSERT(a_rise_clears_sum, clk, rst, !$rose(out_valid) || running_sum == 31'd0)

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  import pcdp_pkg::*;

  // One directed request with an optional hand-computed sum.
  typedef struct packed {
    logic [3:0]  depth;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        last;
    logic        pinned;
    logic [30:0] sum;
  } vec_row_t;

  localparam int NUM_ROWS = 16;
  localparam vec_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{4'd8,  8'hFF, 8'hFF, 1'b1, 1'b1, 31'd65025},
    '{4'd8,  8'h00, 8'hFF, 1'b1, 1'b1, 31'd0},
    '{4'd8,  8'h03, 8'h05, 1'b0, 1'b0, 31'd0},
    '{4'd8,  8'h02, 8'h04, 1'b1, 1'b0, 31'd0},
    '{4'd6,  8'hFF, 8'hFF, 1'b1, 1'b1, 31'd3969},
    '{4'd6,  8'hFF, 8'hFF, 1'b0, 1'b0, 31'd0},
    '{4'd6,  8'hFF, 8'hFF, 1'b0, 1'b0, 31'd0},
    '{4'd6,  8'hFF, 8'hFF, 1'b1, 1'b1, 31'd15876},
    '{4'd7,  8'hFF, 8'hFF, 1'b1, 1'b1, 31'd16129},
    '{4'd0,  8'hFF, 8'hFF, 1'b1, 1'b1, 31'd3969},
    '{4'd15, 8'hFF, 8'hFF, 1'b1, 1'b1, 31'd65025},
    '{4'd9,  8'hAA, 8'h55, 1'b1, 1'b1, 31'd14450},
    '{4'd5,  8'h3F, 8'h01, 1'b1, 1'b1, 31'd63},
    '{4'd7,  8'h80, 8'h01, 1'b0, 1'b0, 31'd0},
    '{4'd7,  8'h01, 8'hFF, 1'b0, 1'b0, 31'd0},
    '{4'd7,  8'h00, 8'h00, 1'b1, 1'b0, 31'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_a = 8'd0;
  logic [7:0]  byte_b = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] dot_product;

  // Predictor copy of the depth register and the per-vector state.
  logic [3:0]  depth_reg = DEPTH_RESET;
  logic [14:0] pend_a = '0;
  logic [14:0] pend_b = '0;
  logic [3:0]  pend_cnt = '0;
  logic [31:0] acc_sum = '0;

  logic [30:0] expected_sums [$];
  int          error_count = 0;
  int          sender_gap_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  packed_code_dot_product_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_a      (byte_a),
    .byte_b      (byte_b),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dot_product (dot_product)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Fold one byte pair into the predicted sum; queue the sum on the last request.
  task automatic fold_byte_pair(input logic [7:0] a, input logic [7:0] b,
                                input logic last, input logic pinned,
                                input logic [30:0] pinned_sum);
    int         eff;
    int         cnt;
    logic [7:0] mask;
    logic [7:0] ca;
    logic [7:0] cb;
    eff = depth_reg;
    if (depth_reg < DEPTH_MIN) eff = DEPTH_MIN;
    if (depth_reg > DEPTH_MAX) eff = DEPTH_MAX;
    mask = 8'((9'd1 << eff) - 9'd1);
    pend_a = pend_a | (15'(a) << pend_cnt);
    pend_b = pend_b | (15'(b) << pend_cnt);
    cnt = int'(pend_cnt) + 8;
    while (cnt >= eff) begin
      ca = pend_a[7:0] & mask;
      cb = pend_b[7:0] & mask;
      acc_sum = acc_sum + 32'(ca) * 32'(cb);
      if (acc_sum > SUM_LIMIT) acc_sum = SUM_LIMIT;
      pend_a = pend_a >> eff;
      pend_b = pend_b >> eff;
      cnt -= eff;
    end
    pend_cnt = 4'(cnt);
    if (last) begin
      expected_sums.push_back(pinned ? pinned_sum : acc_sum[30:0]);
      pend_a = '0;
      pend_b = '0;
      pend_cnt = '0;
      acc_sum = '0;
    end
  endtask

  // Offer one request after random gaps; return at the edge that takes it.
  task automatic offer_byte_pair(input logic [7:0] a, input logic [7:0] b,
                                 input logic last, input logic pinned,
                                 input logic [30:0] pinned_sum);
    logic stalled;
    while ($urandom_range(1, 100) <= sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    byte_a    <= a;
    byte_b    <= b;
    last_byte <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    fold_byte_pair(a, b, last, pinned, pinned_sum);
  endtask

  // Drop valid and hold until every queued sum has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  // Write the depth register once the pipeline has emptied.
  task automatic set_depth(input logic [3:0] value);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    depth_reg = value;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Stream random vectors, mostly short, at one depth and one idling mix.
  task automatic run_phase(input int gap_pct, input int stall_pct,
                           input logic [3:0] depth, input int n_items);
    int sent;
    int len;
    set_depth(depth);
    sender_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        offer_byte_pair(pick_byte(), pick_byte(), i == len - 1, 1'b0, '0);
      sent += len;
    end
  endtask

  // Drive out_stall: random stalls, or one long counted hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // Compare each taken result with the oldest queued sum.
  always @(negedge clk) begin
    logic [30:0] want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (expected_sums.size() == 0) begin
        flag_mismatch($sformatf("result %0d with no request waiting", dot_product));
      end else begin
        want = expected_sums.pop_front();
        if (dot_product !== want)
          flag_mismatch($sformatf("dot_product %0d, want %0d", dot_product, want));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; depth changes fall on vector boundaries.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].depth != depth_reg) set_depth(DIRECTED_ROWS[r].depth);
      offer_byte_pair(DIRECTED_ROWS[r].a, DIRECTED_ROWS[r].b, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].sum);
    end

    // Random vectors under each idling mix.
    run_phase(0, 0, 4'd6, 120);
    run_phase(0, 0, 4'd8, 120);
    run_phase(75, 0, 4'd7, 120);
    run_phase(75, 0, 4'($urandom_range(0, 15)), 120);
    run_phase(0, 75, 4'd15, 120);
    run_phase(0, 75, 4'd0, 120);
    run_phase(33, 33, 4'($urandom_range(0, 15)), 120);
    run_phase(33, 33, 4'd7, 120);

    // Hold off the receiver while requests keep coming, then pause until drained.
    set_depth(4'd6);
    sender_gap_pct = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    for (int v = 0; v < 6; v++)
      for (int i = 0; i < 10; i++)
        offer_byte_pair(pick_byte(), pick_byte(), i == 9, 1'b0, '0);
    drain_results();
    recv_stall_pct = 33;
    for (int i = 0; i < 12; i++)
      offer_byte_pair(pick_byte(), pick_byte(), i == 11, 1'b0, '0);

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
